// ===== rtl/heac_pkg.sv =====
// Package for the Hall edge angle calibrator: commands, actions and payload structs.
// Used by every module under rtl/.
`default_nettype none
package heac_pkg;

  localparam int NumCh = 6;
  localparam int AngleBits = 16;
  localparam logic [6:0] StatusMid = 7'd50;
  localparam logic [6:0] StatusGain = 7'd100;
  localparam logic [15:0] ThreshReset = 16'd16;

  typedef enum logic [1:0] {
    CMD_BEGIN  = 2'd0,
    CMD_SAMPLE = 2'd1,
    CMD_CHECK  = 2'd2,
    CMD_FINISH = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ACT_NONE    = 2'd0,
    ACT_REVERSE = 2'd1,
    ACT_STOP    = 2'd2
  } act_t;

  typedef struct packed {
    logic [1:0]                cmd;
    logic signed [AngleBits-1:0] rotor_angle;
    logic [2:0]                hall_bits;
  } req_t;

  typedef struct packed {
    logic [1:0]                action;
    logic                      ready_res;
    logic [2:0]                channel;
    logic signed [AngleBits-1:0] rise_angle;
    logic signed [AngleBits-1:0] fall_angle;
    logic                      rise_valid;
    logic                      fall_valid;
    logic                      last;
  } res_t;

endpackage
`default_nettype wire

// ===== rtl/heac_queue.sv =====
// Two-entry request queue between the command front end and the execution back end.
// Depends on heac_pkg.
`default_nettype none
module heac_queue (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            push,
  input  wire heac_pkg::req_t  push_data,
  input  wire logic            pop,
  output heac_pkg::req_t       head,
  output logic                 not_empty,
  output logic                 full
);
  import heac_pkg::*;

  req_t       slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] fill;

  assign head = slots[rd_ptr];
  assign not_empty = (fill != 2'd0);
  assign full = (fill == 2'd2);

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop) rd_ptr <= ~rd_ptr;
      fill <= fill + {1'b0, push} - {1'b0, pop};
    end
  end

`ifndef NO_ASSERTIONS
  a_no_overflow: assert property (@(posedge clk) disable iff (rst) !(push && full && !pop))
    else $error("queue overflow");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst) !(pop && !not_empty))
    else $error("queue underflow");
  a_fill_range: assert property (@(posedge clk) disable iff (rst) fill != 2'd3)
    else $error("queue fill out of range");
`endif
endmodule
`default_nettype wire

// ===== rtl/heac_exec.sv =====
// Execution back end: per-channel filters, edge accumulation, check and finish reports.
// Depends on heac_pkg; sums are divided by their counts, one channel after another, with a serial divider.
`default_nettype none
module heac_exec #(
  parameter int SUM_BITS = 32,
  parameter int COUNT_BITS = 16
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic [15:0]     min_edge_count,
  input  wire heac_pkg::req_t  req,
  input  wire logic            req_valid,
  output logic                 req_pop,
  output logic                 idle,
  output logic                 res_strobe,
  output heac_pkg::res_t       res
);
  import heac_pkg::*;

  localparam int ANGLE_BITS = AngleBits;
  localparam int DivBits = SUM_BITS + 1;
  localparam int CntIdx = $clog2(SUM_BITS + 2);

  typedef enum logic [2:0] {
    S_IDLE, S_SAMPLE, S_DIV_LOAD, S_DIV_RUN, S_DIV_DONE, S_EMIT
  } state_t;

  state_t state;
  logic [ANGLE_BITS-1:0] rise_first [NumCh];
  logic [ANGLE_BITS-1:0] fall_first [NumCh];
  logic [SUM_BITS-1:0]   rise_sum   [NumCh];
  logic [SUM_BITS-1:0]   fall_sum   [NumCh];
  logic [COUNT_BITS-1:0] rise_count [NumCh];
  logic [COUNT_BITS-1:0] fall_count [NumCh];
  logic [NumCh-1:0]      line_prev;
  logic [6:0]            line_status [NumCh];
  logic                  direction;
  logic [ANGLE_BITS-1:0] prev_angle;

  req_t                  cur;
  logic [1:0]            lane;
  logic [2:0]            ch;
  logic                  pol;
  logic [DivBits-1:0]    dividend;
  logic [DivBits-1:0]    rem;
  logic [COUNT_BITS-1:0] divisor;
  logic                  neg;
  logic [CntIdx-1:0]     bit_cnt;
  logic [ANGLE_BITS-1:0] rise_mean;

  logic [ANGLE_BITS-1:0] ang;
  assign ang = ANGLE_BITS'(unsigned'(cur.rotor_angle));

  // Sample datapath for one lane.
  logic [2:0]            sc;
  logic                  hb;
  logic [8:0]            st_acc;
  logic [6:0]            st_new;
  logic                  is_rise, is_fall, to_rise, hit;
  logic [ANGLE_BITS-1:0] d, shr, half, mid, diff;
  logic [COUNT_BITS-1:0] cnt_sel;
  logic [ANGLE_BITS-1:0] first_sel;
  always_comb begin
    sc = direction ? 3'(lane) + 3'd3 : 3'(lane);
    hb = cur.hall_bits[lane];
    st_acc = 9'(line_status[sc]) * 9'd3 + (hb ? 9'(StatusGain) : 9'd0) + 9'd2;
    st_new = st_acc[8:2];
    is_rise = !line_prev[sc] && hb && (st_new <= StatusMid);
    is_fall = line_prev[sc] && !hb && (st_new >= StatusMid);
    to_rise = (is_rise && !direction) || (is_fall && direction);
    hit = is_rise || is_fall;
    cnt_sel = to_rise ? rise_count[sc] : fall_count[sc];
    first_sel = to_rise ? rise_first[sc] : fall_first[sc];
    d = ang - prev_angle;
    // halve toward zero
    shr = $signed(d) >>> 1;
    half = shr + ANGLE_BITS'(d[ANGLE_BITS-1] & d[0]);
    mid = prev_angle + half;
    diff = mid - first_sel;
  end

  // Finish datapath: magnitude of sum + count/2, restoring divide.
  logic [COUNT_BITS-1:0] f_cnt;
  logic [SUM_BITS-1:0]   f_sum;
  logic [DivBits-1:0]    f_num;
  logic [DivBits-1:0]    trial;
  logic [ANGLE_BITS-1:0] q_angle;
  logic [ANGLE_BITS-1:0] mean;
  always_comb begin
    f_cnt = pol ? fall_count[ch] : rise_count[ch];
    f_sum = pol ? fall_sum[ch] : rise_sum[ch];
    f_num = DivBits'($signed(f_sum)) + DivBits'(f_cnt >> 1);
    trial = {rem[DivBits-2:0], dividend[DivBits-1]};
    q_angle = ANGLE_BITS'(dividend);
    mean = (pol ? fall_first[ch] : rise_first[ch]) + (neg ? -q_angle : q_angle);
  end

  logic ready_all;
  always_comb begin
    ready_all = 1'b1;
    for (int i = 0; i < 3; i++) begin
      if (!(32'(rise_count[(direction ? 3 : 0) + i]) > 32'(min_edge_count)
            && 32'(fall_count[(direction ? 3 : 0) + i]) > 32'(min_edge_count)))
        ready_all = 1'b0;
    end
  end

  assign req_pop = (state == S_IDLE) && req_valid;
  assign idle = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      res_strobe <= 1'b0;
      direction <= 1'b0;
      prev_angle <= '0;
      line_prev <= '0;
      for (int i = 0; i < NumCh; i++) begin
        rise_first[i] <= '0; fall_first[i] <= '0;
        rise_sum[i] <= '0; fall_sum[i] <= '0;
        rise_count[i] <= '0; fall_count[i] <= '0;
        line_status[i] <= StatusMid;
      end
    end else begin
      res_strobe <= 1'b0;
      case (state)
        S_IDLE: begin
          if (req_valid) begin
            cur <= req;
            lane <= 2'd0;
            ch <= 3'd0;
            pol <= 1'b0;
            case (cmd_t'(req.cmd))
              CMD_BEGIN: begin
                direction <= 1'b0;
                for (int i = 0; i < 3; i++) begin
                  rise_sum[i] <= '0; fall_sum[i] <= '0;
                  rise_count[i] <= '0; fall_count[i] <= '0;
                  line_status[i] <= StatusMid;
                  line_prev[i] <= req.hall_bits[i];
                end
              end
              CMD_SAMPLE: state <= S_SAMPLE;
              CMD_CHECK: state <= S_EMIT;
              CMD_FINISH: state <= S_DIV_LOAD;
              default: state <= S_IDLE;
            endcase
          end
        end
        S_SAMPLE: begin
          line_status[sc] <= st_new;
          line_prev[sc] <= hb;
          if (hit && cnt_sel != '1) begin
            if (to_rise) begin
              rise_count[sc] <= rise_count[sc] + 1'b1;
              if (rise_count[sc] == '0) begin
                rise_sum[sc] <= '0; rise_first[sc] <= ang;
              end else begin
                rise_sum[sc] <= rise_sum[sc] + SUM_BITS'($signed(diff));
              end
            end else begin
              fall_count[sc] <= fall_count[sc] + 1'b1;
              if (fall_count[sc] == '0) begin
                fall_sum[sc] <= '0; fall_first[sc] <= ang;
              end else begin
                fall_sum[sc] <= fall_sum[sc] + SUM_BITS'($signed(diff));
              end
            end
          end
          lane <= lane + 2'd1;
          if (lane == 2'd2) begin
            prev_angle <= ang;
            state <= S_IDLE;
          end
        end
        S_DIV_LOAD: begin
          neg <= f_num[DivBits-1];
          dividend <= f_num[DivBits-1] ? -f_num : f_num;
          rem <= '0;
          divisor <= f_cnt;
          bit_cnt <= CntIdx'(DivBits);
          state <= (f_cnt == '0) ? S_DIV_DONE : S_DIV_RUN;
        end
        S_DIV_RUN: begin
          // one quotient bit per cycle
          if (trial >= DivBits'(divisor)) begin
            rem <= trial - DivBits'(divisor);
            dividend <= {dividend[DivBits-2:0], 1'b1};
          end else begin
            rem <= trial;
            dividend <= {dividend[DivBits-2:0], 1'b0};
          end
          bit_cnt <= bit_cnt - 1'b1;
          if (bit_cnt == CntIdx'(1)) state <= S_DIV_DONE;
        end
        S_DIV_DONE: begin
          if (!pol) begin
            rise_mean <= (f_cnt == '0) ? '0 : mean;
            pol <= 1'b1;
            state <= S_DIV_LOAD;
          end else begin
            res_strobe <= 1'b1;
            res.action <= ACT_NONE;
            res.ready_res <= 1'b0;
            res.channel <= ch;
            res.rise_angle <= rise_mean;
            res.fall_angle <= (f_cnt == '0) ? '0 : mean;
            res.rise_valid <= (rise_count[ch] != '0);
            res.fall_valid <= (f_cnt != '0);
            res.last <= (ch == 3'(NumCh - 1));
            pol <= 1'b0;
            ch <= ch + 3'd1;
            state <= (ch == 3'(NumCh - 1)) ? S_IDLE : S_DIV_LOAD;
          end
        end
        S_EMIT: begin
          res_strobe <= 1'b1;
          res.ready_res <= ready_all;
          res.channel <= 3'd0;
          res.rise_angle <= '0;
          res.fall_angle <= '0;
          res.rise_valid <= 1'b0;
          res.fall_valid <= 1'b0;
          res.last <= 1'b1;
          if (ready_all) begin
            if (!direction) begin
              res.action <= ACT_REVERSE;
              direction <= 1'b1;
              for (int i = 3; i < NumCh; i++) begin
                rise_sum[i] <= '0; fall_sum[i] <= '0;
                rise_count[i] <= '0; fall_count[i] <= '0;
                line_status[i] <= StatusMid;
                line_prev[i] <= cur.hall_bits[i-3];
              end
            end else begin
              res.action <= ACT_STOP;
            end
          end else begin
            res.action <= ACT_NONE;
          end
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  a_pop_idle: assert property (@(posedge clk) disable iff (rst) req_pop |-> idle)
    else $error("pop outside idle");
  a_sample_len: assert property (@(posedge clk) disable iff (rst)
      (state == S_SAMPLE && lane == 2'd2) |=> state == S_IDLE)
    else $error("sample overran lanes");
  a_strobe_src: assert property (@(posedge clk) disable iff (rst)
      res_strobe |-> ($past(state) == S_EMIT || $past(state) == S_DIV_DONE))
    else $error("stray result strobe");
`endif
endmodule
`default_nettype wire

// ===== rtl/heac_front.sv =====
// Front end: command intake, threshold register and busy generation.
// Depends on heac_pkg.
`default_nettype none
module heac_front (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            start,
  input  wire heac_pkg::req_t  in_req,
  input  wire logic            cfg_valid,
  input  wire logic [15:0]     cfg_data,
  input  wire logic            q_full,
  output logic                 busy,
  output logic                 cfg_ready,
  output logic                 push,
  output heac_pkg::req_t       push_data,
  output logic [15:0]          min_edge_count
);
  import heac_pkg::*;

  assign busy = q_full;
  assign push = start && !busy;
  assign push_data = in_req;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      min_edge_count <= ThreshReset;
    end else if (cfg_valid && cfg_ready) begin
      min_edge_count <= cfg_data;
    end
  end

`ifndef NO_ASSERTIONS
  a_push_gate: assert property (@(posedge clk) disable iff (rst) push |-> !q_full)
    else $error("push into full queue");
  a_cfg_hold: assert property (@(posedge clk) disable iff (rst)
      !$past(cfg_valid) |-> $stable(min_edge_count))
    else $error("threshold changed without write");
  a_reset_val: assert property (@(posedge clk) rst |=> min_edge_count == ThreshReset)
    else $error("threshold reset value");
`endif
endmodule
`default_nettype wire

// ===== rtl/hall_edge_angle_calibrator.sv =====
// Top level of the Hall edge angle calibrator: front end, request queue, back end.
// Depends on heac_pkg, heac_front, heac_queue, heac_exec.
//
//  channel | handshake             | payload
//  input   | start / busy          | in_req (cmd, rotor_angle, hall_bits)
//  result  | res_strobe            | res (action .. last)
//  config  | cfg_valid / cfg_ready | cfg_data (min_edge_count)
//
// Begin is handled in the back end's idle state, sample visits the three Hall lines
// in turn, and check passes through the emit state. Finish runs the serial divider
// twelve times, rise then fall for each channel, for six results. A two-entry queue
// absorbs requests; busy rises while it is full. Reset is synchronous on rst;
// threshold resets to 16. Results show for one cycle and cannot be held off.
`default_nettype none
module hall_edge_angle_calibrator #(
  parameter int SUM_BITS = 32,
  parameter int COUNT_BITS = 16
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            start,
  output logic                 busy,
  input  wire heac_pkg::req_t  in_req,
  output logic                 res_strobe,
  output heac_pkg::res_t       res,
  input  wire logic            cfg_valid,
  output logic                 cfg_ready,
  input  wire logic [15:0]     cfg_data
);
  import heac_pkg::*;

  logic        push, pop, q_ne, q_full, ex_idle;
  req_t        push_data, head;
  logic [15:0] min_edge_count;

  heac_front u_front (
    .clk, .rst, .start, .in_req, .cfg_valid, .cfg_data, .q_full,
    .busy, .cfg_ready, .push, .push_data, .min_edge_count
  );

  heac_queue u_queue (
    .clk, .rst, .push, .push_data, .pop, .head, .not_empty(q_ne), .full(q_full)
  );

  heac_exec #(
    .SUM_BITS(SUM_BITS), .COUNT_BITS(COUNT_BITS)
  ) u_exec (
    .clk, .rst, .min_edge_count, .req(head), .req_valid(q_ne), .req_pop(pop),
    .idle(ex_idle), .res_strobe, .res
  );

`ifndef NO_ASSERTIONS
  a_busy_full: assert property (@(posedge clk) disable iff (rst) busy == q_full)
    else $error("busy mismatch");
  a_pop_ready: assert property (@(posedge clk) disable iff (rst) pop |-> (q_ne && ex_idle))
    else $error("pop without work");
  a_strobe_last: assert property (@(posedge clk) disable iff (rst)
      (res_strobe && res.channel == 3'd5) |-> res.last)
    else $error("last flag missing");
`endif
endmodule
`default_nettype wire
